[src/cbmu_pkg.sv]
`timescale 1ns / 1ps

package cbmu_pkg;

	localparam int REG_COUNT_DEF = 32;

	// register file is banked by the low two index bits, one bank per word of an aligned group
	localparam int LANES  = 4;
	localparam int LANE_W = $clog2(LANES);

	localparam logic [2:0] CC_LESS    = 3'd4;
	localparam logic [2:0] CC_EQUAL   = 3'd2;
	localparam logic [2:0] CC_GREATER = 3'd1;
	localparam logic [2:0] CC_NONE    = 3'd0;
	localparam logic [4:0] BIT_MASK   = 5'd31;

	typedef enum logic [1:0] {
		K_CMP  = 2'd0,
		K_BIT  = 2'd1,
		K_MOVE = 2'd2,
		K_ORD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOB   = 2'd1,
		ST_UNSUP = 2'd2
	} status_t;

	// compare branch selectors
	localparam logic [2:0] COND_G  = 3'd0;
	localparam logic [2:0] COND_E  = 3'd1;
	localparam logic [2:0] COND_GE = 3'd2;
	localparam logic [2:0] COND_L  = 3'd3;
	localparam logic [2:0] COND_NE = 3'd4;
	localparam logic [2:0] COND_LE = 3'd5;
	localparam logic [2:0] COND_O  = 3'd6;
	localparam logic [2:0] COND_NO = 3'd7;

	// bit test, move and ordered selectors
	localparam logic [2:0] SEL_BBS   = 3'd0;
	localparam logic [2:0] SEL_BBC   = 3'd1;
	localparam logic [2:0] SEL_TWO   = 3'd0;
	localparam logic [2:0] SEL_THREE = 3'd1;
	localparam logic [2:0] SEL_FOUR  = 3'd2;
	localparam logic [2:0] SEL_BO    = 3'd0;
	localparam logic [2:0] SEL_BNO   = 3'd1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  condition;
		logic        signed_compare;
		logic        a_from_reg;
		logic [4:0]  a_reg;
		logic [31:0] a_imm;
		logic        b_from_reg;
		logic [4:0]  b_reg;
		logic [31:0] b_imm;
		logic [3:0]  insn_bytes;
		logic [31:0] branch_target;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] next_pc;
		logic        taken;
		logic [2:0]  cond_code;
		logic [31:0] step_number;
	} rsp_t;

endpackage

[src/cbmu_if.sv]
`timescale 1ns / 1ps

interface cbmu_req_if
	import cbmu_pkg::*;
	();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbmu_rsp_if
	import cbmu_pkg::*;
	();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/compare_branch_move_unit.sv]
`timescale 1ns / 1ps

// Execute stage for compare-and-branch, bit-test branch, literal multi-move and
// branch-on-ordered instructions. One instruction is accepted every cycle unless the
// pipe stalls, and its result is registered in the output register as the second
// stage fires: the register file lives in four banked RAMs (one per word of an
// aligned group of four) read as the transaction is accepted, and the second
// stage resolves operands, updates pc, condition code and step count, and writes
// a move back in the same cycle. A move issued just before is forwarded to the
// next instruction. Registers read as zero until first written, tracked by one
// valid flop per register; there is no clearing pass after reset. A full output
// register stalls the pipe only when the second stage also holds an instruction.
module compare_branch_move_unit
	import cbmu_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cbmu_req_if.sink  req,
	cbmu_rsp_if.source rsp
);

	localparam int ROWS  = (REG_COUNT + LANES - 1) / LANES;
	localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;

	function automatic logic [ROW_W-1:0] row_of(input logic [4:0] idx);
		logic [ROW_W+2:0] ext;
		ext = {{ROW_W{1'b0}}, idx[4:LANE_W]};
		return ext[ROW_W-1:0];
	endfunction

	function automatic logic cond_holds(input logic [2:0] sel, input logic [2:0] cc);
		logic r;
		case (sel)
			COND_G:  r = (cc == CC_GREATER);
			COND_E:  r = (cc == CC_EQUAL);
			COND_GE: r = (cc == CC_GREATER) || (cc == CC_EQUAL);
			COND_L:  r = (cc == CC_LESS);
			COND_NE: r = (cc != CC_EQUAL);
			COND_LE: r = (cc == CC_LESS) || (cc == CC_EQUAL);
			COND_O:  r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// pipeline and architectural state
	logic                        v_s1;
	req_t                        d_s1;
	logic                        fwd_s1;
	logic                        out_v_q;
	rsp_t                        rsp_q;
	logic [31:0]                 pc_q;
	logic [2:0]                  cc_q;
	logic [31:0]                 cnt_q;
	logic [ROWS-1:0][LANES-1:0]  valid_q;
	logic [ROW_W-1:0]            w_row_q;
	logic [LANES-1:0]            w_mask_q;
	logic [31:0]                 w_data_q [LANES];

	logic accept;
	logic s1_fire;
	logic wr_en;

	logic [31:0] rd_a [LANES];
	logic [31:0] rd_b [LANES];
	logic [31:0] lane_a [LANES];
	logic [31:0] lane_b [LANES];
	logic [31:0] wr_data [LANES];
	logic [LANES-1:0] wr_mask;

	logic [ROW_W-1:0] row_a_s1;
	logic [ROW_W-1:0] row_b_s1;
	logic [31:0]      a_val;
	logic [31:0]      b_val;
	status_t          status;
	logic             taken;
	logic [2:0]       new_cc;
	logic             a_oob;
	logic             b_oob;
	logic             bit_set;
	logic             less;
	logic [LANE_W-1:0] dst_lane;

	assign s1_fire   = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || s1_fire;
	assign accept    = req.valid && req.ready;

	assign row_a_s1 = row_of(d_s1.a_reg);
	assign row_b_s1 = row_of(d_s1.b_reg);
	assign dst_lane = d_s1.b_reg[LANE_W-1:0];

	for (genvar l = 0; l < LANES; l++) begin : g_bank
		cbmu_ram #(
			.WIDTH (32),
			.DEPTH (ROWS)
		) u_bank (
			.clk     (clk),
			.we      (wr_en && wr_mask[l]),
			.waddr   (row_b_s1),
			.wdata   (wr_data[l]),
			.re      (accept),
			.raddr_a (row_of(req.data.a_reg)),
			.raddr_b (row_of(req.data.b_reg)),
			.rdata_a (rd_a[l]),
			.rdata_b (rd_b[l])
		);
	end

	// the move written at the read edge is not yet in the read data
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (fwd_s1 && w_mask_q[l] && (w_row_q == row_a_s1)) begin
				lane_a[l] = w_data_q[l];
			end else if (valid_q[row_a_s1][l]) begin
				lane_a[l] = rd_a[l];
			end else begin
				lane_a[l] = '0;
			end
			if (fwd_s1 && w_mask_q[l] && (w_row_q == row_b_s1)) begin
				lane_b[l] = w_data_q[l];
			end else if (valid_q[row_b_s1][l]) begin
				lane_b[l] = rd_b[l];
			end else begin
				lane_b[l] = '0;
			end
		end
	end

	assign a_val = d_s1.a_from_reg ? lane_a[d_s1.a_reg[LANE_W-1:0]] : d_s1.a_imm;
	assign b_val = d_s1.b_from_reg ? lane_b[d_s1.b_reg[LANE_W-1:0]] : d_s1.b_imm;

	assign a_oob   = d_s1.a_from_reg && (32'(d_s1.a_reg) >= 32'(REG_COUNT));
	assign b_oob   = d_s1.b_from_reg && (32'(d_s1.b_reg) >= 32'(REG_COUNT));
	assign bit_set = b_val[a_val[4:0] & BIT_MASK];
	assign less    = d_s1.signed_compare ? ($signed(a_val) < $signed(b_val)) : (a_val < b_val);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			wr_data[l] = (LANE_W'(l) == dst_lane) ? d_s1.a_imm : '0;
		end
		case (d_s1.condition)
			SEL_TWO:   wr_mask = d_s1.b_reg[1] ? 4'b1100 : 4'b0011;
			SEL_THREE: wr_mask = 4'b0111;
			SEL_FOUR:  wr_mask = 4'b1111;
			default:   wr_mask = 4'b0000;
		endcase
	end

	always_comb begin
		status = ST_OK;
		taken  = 1'b0;
		new_cc = cc_q;
		case (d_s1.req_type)
			K_CMP, K_BIT: begin
				if (d_s1.req_type == K_BIT && d_s1.condition > SEL_BBC) begin
					status = ST_UNSUP;
				end else if (a_oob || b_oob) begin
					status = ST_OOB;
				end else if (d_s1.req_type == K_CMP) begin
					if (less) begin
						new_cc = CC_LESS;
					end else if (a_val == b_val) begin
						new_cc = CC_EQUAL;
					end else begin
						new_cc = CC_GREATER;
					end
					taken = cond_holds(d_s1.condition, new_cc);
				end else begin
					new_cc = bit_set ? CC_EQUAL : CC_NONE;
					taken  = (d_s1.condition == SEL_BBS) ? bit_set : !bit_set;
				end
			end
			K_MOVE: begin
				if (d_s1.condition > SEL_FOUR || d_s1.a_from_reg || !d_s1.b_from_reg) begin
					status = ST_UNSUP;
				end else if (32'(d_s1.b_reg) + 32'(d_s1.condition) + 32'd2
						> 32'(REG_COUNT)) begin
					status = ST_OOB;
				end else if (d_s1.condition == SEL_TWO ? d_s1.b_reg[0]
						: (d_s1.b_reg[1:0] != 2'b00)) begin
					status = ST_UNSUP;
				end
			end
			default: begin
				if (d_s1.condition > SEL_BNO) begin
					status = ST_UNSUP;
				end else begin
					taken = (d_s1.condition == SEL_BO) ? (cc_q != CC_NONE) : (cc_q == CC_NONE);
				end
			end
		endcase
	end

	assign wr_en = s1_fire && (status == ST_OK) && (d_s1.req_type == K_MOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_s1  <= 1'b0;
			out_v_q <= 1'b0;
			pc_q    <= '0;
			cc_q    <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else begin
			if (accept) begin
				v_s1   <= 1'b1;
				fwd_s1 <= wr_en;
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (s1_fire && status == ST_OK) begin
				cc_q  <= new_cc;
				pc_q  <= taken ? d_s1.branch_target : pc_q + 32'(d_s1.insn_bytes);
				cnt_q <= cnt_q + 32'd1;
			end
			if (wr_en) begin
				valid_q[row_b_s1] <= valid_q[row_b_s1] | wr_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1 <= req.data;
		end
		if (wr_en) begin
			w_row_q  <= row_b_s1;
			w_mask_q <= wr_mask;
			w_data_q <= wr_data;
		end
		if (s1_fire) begin
			rsp_q.status      <= status;
			rsp_q.taken       <= taken;
			if (status == ST_OK) begin
				rsp_q.next_pc     <= taken ? d_s1.branch_target
					: pc_q + 32'(d_s1.insn_bytes);
				rsp_q.cond_code   <= new_cc;
				rsp_q.step_number <= cnt_q + 32'd1;
			end else begin
				rsp_q.next_pc     <= pc_q;
				rsp_q.cond_code   <= cc_q;
				rsp_q.step_number <= cnt_q;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = rsp_q;

endmodule

[src/cbmu_ram.sv]
`timescale 1ns / 1ps

module cbmu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_a,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
